// ===== rtl/sod_pkg.sv =====
// ----------------------------------------------------------------------------
// sod_pkg
// Shared types and constants of the send-on-delta reporter.
// ----------------------------------------------------------------------------
package sod_pkg;

  localparam int TEMP_W = 15;
  localparam int HUM_W  = 14;
  localparam int BATT_W = 10;
  localparam int INT_W  = 16;
  localparam int CHEN_W = 3;
  localparam int WAKE_W = 32;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  localparam logic [TEMP_W-1:0] TEMP_DELTA_RST    = 15'd50;
  localparam logic [HUM_W-1:0]  HUM_DELTA_RST     = 14'd200;
  localparam logic [BATT_W-1:0] VOLT_DELTA_RST    = 10'd24;
  localparam logic [INT_W-1:0]  MAX_INTERVAL_RST  = 16'd72;
  localparam logic [BATT_W-1:0] LOW_BATT_RST      = 10'd737;
  localparam logic [CHEN_W-1:0] CHANNEL_EN_RST    = 3'd5;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TEMP_DELTA     = 3'd0,
    REG_HUMIDITY_DELTA = 3'd1,
    REG_VOLTAGE_DELTA  = 3'd2,
    REG_MAX_INTERVAL   = 3'd3,
    REG_LOW_BATTERY    = 3'd4,
    REG_CHANNEL_ENABLE = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_LOW_BATTERY = 3'd0,
    ST_OTA         = 3'd1,
    ST_SENSOR_FAIL = 3'd2,
    ST_NO_UPDATE   = 3'd3,
    ST_SENT_OK     = 3'd4,
    ST_SEND_FAIL   = 3'd5
  } status_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temp_delta;
    logic [HUM_W-1:0]  humidity_delta;
    logic [BATT_W-1:0] voltage_delta;
    logic [INT_W-1:0]  max_interval;
    logic [BATT_W-1:0] low_battery_level;
    logic [CHEN_W-1:0] channel_enable;
  } cfg_t;

  // packed from the top bit down: temperature lands in the lowest bits
  typedef struct packed {
    logic                     delivery_ok;
    logic                     ota_request;
    logic                     sensor_ok;
    logic [BATT_W-1:0]        battery_raw;
    logic [HUM_W-1:0]         humidity_centi;
    logic signed [TEMP_W-1:0] temperature_centi;
  } item_t;

  typedef struct packed {
    logic [WAKE_W-1:0] wake_number;
    logic              send_voltage;
    logic              send_humidity;
    logic              send_temperature;
    status_t           status;
  } result_t;

endpackage

// ===== rtl/send_on_delta_reporter.sv =====
// ----------------------------------------------------------------------------
// send_on_delta_reporter
// Send-on-delta reporting decision with heartbeat for a battery sensor node.
// ----------------------------------------------------------------------------
// Each input transfer on in_* is one wake-up of the node; each produces one
// result transfer on out_* with the status, the per-channel send flags and
// the wake count after the step. Items go through an input register, the
// decision logic and a result register, so each result passes through both
// registers after its input transfer. One item per cycle is sustained: the
// input side keeps taking items while a result waits, as long as the result
// register can advance. When out_tready is low, the result holds and in_tready
// drops as soon as the input register holds an item; no item is lost.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata and
// take effect at once; write them only while no item is in flight.
// Reset (rst_n low, synchronous) empties both registers, loads the register
// defaults and clears history: the next counted wake-up is a first start.
// ----------------------------------------------------------------------------
module send_on_delta_reporter #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // temperature_centi[14:0], humidity_centi[28:15], battery_raw[38:29],
  // sensor_ok[39], ota_request[40], delivery_ok[41], zero fill
  input  logic [sod_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status[2:0], send_temperature[3], send_humidity[4], send_voltage[5],
  // wake_number[37:6], zero fill
  output logic [sod_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_we,
  input  logic [sod_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sod_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int ITEM_W = $bits(sod_pkg::item_t);
  localparam int RES_W  = $bits(sod_pkg::result_t);

  sod_pkg::cfg_t    cfg;
  sod_pkg::item_t   item_r;
  sod_pkg::result_t res;
  sod_pkg::result_t res_r;
  logic             in_vld_r, in_vld_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic             advance;

  sod_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sod_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .cfg     (cfg),
    .result  (res)
  );

  always_comb begin
    advance     = in_vld_r && (!out_vld_r || out_tready);
    in_tready   = !in_vld_r || advance;
    in_vld_nxt  = in_tready ? in_tvalid : in_vld_r;
    out_vld_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= sod_pkg::item_t'(in_tdata[ITEM_W-1:0]);
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(sod_pkg::OUT_TDATA_W-RES_W){1'b0}}, res_r};

  a_early_exit_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (res_r.status == sod_pkg::ST_LOW_BATTERY ||
                  res_r.status == sod_pkg::ST_OTA ||
                  res_r.status == sod_pkg::ST_SENSOR_FAIL ||
                  res_r.status == sod_pkg::ST_NO_UPDATE)
    |-> !(res_r.send_temperature || res_r.send_humidity || res_r.send_voltage))
    else $error("send flag set without a report");

  a_report_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (res_r.status == sod_pkg::ST_SENT_OK || res_r.status == sod_pkg::ST_SEND_FAIL)
    |-> (res_r.send_temperature || res_r.send_humidity || res_r.send_voltage))
    else $error("report status without any channel flagged");

  a_flags_follow_enable: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> !((res.send_temperature && !cfg.channel_enable[0]) ||
                  (res.send_humidity && !cfg.channel_enable[1]) ||
                  (res.send_voltage && !cfg.channel_enable[2])))
    else $error("disabled channel flagged for reporting");

endmodule

// ===== rtl/sod_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sod_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module sod_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sod_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [sod_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output sod_pkg::cfg_t                    cfg
);

  sod_pkg::cfg_t cfg_r;
  sod_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        sod_pkg::REG_TEMP_DELTA:
          cfg_nxt.temp_delta = cfg_wdata[sod_pkg::TEMP_W-1:0];
        sod_pkg::REG_HUMIDITY_DELTA:
          cfg_nxt.humidity_delta = cfg_wdata[sod_pkg::HUM_W-1:0];
        sod_pkg::REG_VOLTAGE_DELTA:
          cfg_nxt.voltage_delta = cfg_wdata[sod_pkg::BATT_W-1:0];
        sod_pkg::REG_MAX_INTERVAL:
          cfg_nxt.max_interval = cfg_wdata[sod_pkg::INT_W-1:0];
        sod_pkg::REG_LOW_BATTERY:
          cfg_nxt.low_battery_level = cfg_wdata[sod_pkg::BATT_W-1:0];
        sod_pkg::REG_CHANNEL_ENABLE:
          cfg_nxt.channel_enable = cfg_wdata[sod_pkg::CHEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_delta        <= sod_pkg::TEMP_DELTA_RST;
      cfg_r.humidity_delta    <= sod_pkg::HUM_DELTA_RST;
      cfg_r.voltage_delta     <= sod_pkg::VOLT_DELTA_RST;
      cfg_r.max_interval      <= sod_pkg::MAX_INTERVAL_RST;
      cfg_r.low_battery_level <= sod_pkg::LOW_BATT_RST;
      cfg_r.channel_enable    <= sod_pkg::CHANNEL_EN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/sod_core.sv =====
// ----------------------------------------------------------------------------
// sod_core
// Wake-up decision logic and report history state.
// ----------------------------------------------------------------------------
module sod_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  sod_pkg::item_t   item,
  input  sod_pkg::cfg_t    cfg,
  output sod_pkg::result_t result
);

  localparam int CMP_W = (COUNT_WIDTH > sod_pkg::INT_W) ? COUNT_WIDTH : sod_pkg::INT_W;

  logic                          hist_r, hist_nxt;
  logic [COUNT_WIDTH-1:0]        wake_r, wake_nxt;
  logic [COUNT_WIDTH-1:0]        last_r, last_nxt;
  logic [sod_pkg::TEMP_W-1:0]    sent_t_r, sent_t_nxt;
  logic [sod_pkg::HUM_W-1:0]     sent_h_r, sent_h_nxt;
  logic [sod_pkg::BATT_W-1:0]    sent_v_r, sent_v_nxt;

  logic [COUNT_WIDTH-1:0]        wake_cnt;
  logic [COUNT_WIDTH-1:0]        last_eff;
  logic [COUNT_WIDTH-1:0]        elapsed;
  logic                          force_all;
  logic signed [16:0]            t_diff, t_dlt;
  logic signed [14:0]            h_diff, h_dlt;
  logic signed [10:0]            v_diff, v_dlt;
  logic                          t_out, h_out, v_out;
  logic                          st, sh, sv;
  sod_pkg::status_t              status;

  always_comb begin
    wake_cnt  = hist_r ? wake_r + COUNT_WIDTH'(1) : COUNT_WIDTH'(1);
    last_eff  = hist_r ? last_r : COUNT_WIDTH'(1);
    elapsed   = wake_cnt - last_eff;
    force_all = !hist_r || (CMP_W'(elapsed) >= CMP_W'(cfg.max_interval));

    t_diff = $signed({{2{item.temperature_centi[sod_pkg::TEMP_W-1]}}, item.temperature_centi})
           - $signed({{2{sent_t_r[sod_pkg::TEMP_W-1]}}, sent_t_r});
    t_dlt  = $signed({2'b00, cfg.temp_delta});
    h_diff = $signed({1'b0, item.humidity_centi}) - $signed({1'b0, sent_h_r});
    h_dlt  = $signed({1'b0, cfg.humidity_delta});
    v_diff = $signed({1'b0, item.battery_raw}) - $signed({1'b0, sent_v_r});
    v_dlt  = $signed({1'b0, cfg.voltage_delta});
    t_out  = (t_diff > t_dlt) || (t_diff < -t_dlt);
    h_out  = (h_diff > h_dlt) || (h_diff < -h_dlt);
    v_out  = (v_diff > v_dlt) || (v_diff < -v_dlt);

    hist_nxt   = hist_r;
    wake_nxt   = wake_r;
    last_nxt   = last_r;
    sent_t_nxt = sent_t_r;
    sent_h_nxt = sent_h_r;
    sent_v_nxt = sent_v_r;
    st = 1'b0;
    sh = 1'b0;
    sv = 1'b0;

    if (item.battery_raw <= cfg.low_battery_level) begin
      status = sod_pkg::ST_LOW_BATTERY;
    end else if (item.ota_request) begin
      status   = sod_pkg::ST_OTA;
      hist_nxt = 1'b0;
    end else if (!item.sensor_ok) begin
      status = sod_pkg::ST_SENSOR_FAIL;
    end else begin
      st = (force_all || t_out) && cfg.channel_enable[0];
      sh = (force_all || h_out) && cfg.channel_enable[1];
      sv = (force_all || v_out) && cfg.channel_enable[2];
      hist_nxt = 1'b1;
      wake_nxt = wake_cnt;
      last_nxt = last_eff;
      if (st || sh || sv) begin
        if (item.delivery_ok) begin
          status   = sod_pkg::ST_SENT_OK;
          last_nxt = wake_cnt;
          if (st) sent_t_nxt = item.temperature_centi;
          if (sh) sent_h_nxt = item.humidity_centi;
          if (sv) sent_v_nxt = item.battery_raw;
        end else begin
          status = sod_pkg::ST_SEND_FAIL;
        end
      end else begin
        status = sod_pkg::ST_NO_UPDATE;
      end
    end

    result.status           = status;
    result.send_temperature = st;
    result.send_humidity    = sh;
    result.send_voltage     = sv;
    result.wake_number      = sod_pkg::WAKE_W'(wake_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r   <= 1'b0;
      wake_r   <= '0;
      last_r   <= '0;
      sent_t_r <= '0;
      sent_h_r <= '0;
      sent_v_r <= '0;
    end else if (advance) begin
      hist_r   <= hist_nxt;
      wake_r   <= wake_nxt;
      last_r   <= last_nxt;
      sent_t_r <= sent_t_nxt;
      sent_h_r <= sent_h_nxt;
      sent_v_r <= sent_v_nxt;
    end
  end

  a_ota_clears_history: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (status == sod_pkg::ST_OTA) |=> !hist_r)
    else $error("update request did not clear history");

  a_counted_sets_history: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (status == sod_pkg::ST_NO_UPDATE || status == sod_pkg::ST_SENT_OK ||
                status == sod_pkg::ST_SEND_FAIL) |=> hist_r)
    else $error("counted wake-up left history invalid");

  a_sent_updates_last: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (status == sod_pkg::ST_SENT_OK) |=> (last_r == wake_r))
    else $error("report time not stored after successful transfer");

  a_early_exit_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (status == sod_pkg::ST_LOW_BATTERY || status == sod_pkg::ST_SENSOR_FAIL)
    |=> $stable(wake_r))
    else $error("wake count moved on an abandoned wake-up");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the send-on-delta reporter.
// ----------------------------------------------------------------------------
// Wake-ups go in through the input stream and are checked against a local
// model of the reporting decision. The model follows the deadbands, the
// heartbeat, first start, update-mode and failure paths, and the stored
// last-sent values. A short directed run is followed by random wake-ups
// under several register settings. The random wake-ups walk around the
// current deadbands so the edges get hit. The sender goes in bursts with
// gaps and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 200000;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [sod_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [sod_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_we = 1'b0;
  logic [sod_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [sod_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  send_on_delta_reporter #(.COUNT_WIDTH(sod_pkg::WAKE_W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // register copy and decision state
  sod_pkg::cfg_t                     cfg_shadow;
  logic                              hist_valid = 1'b0;
  logic [sod_pkg::WAKE_W-1:0]        wakes = '0;
  logic [sod_pkg::WAKE_W-1:0]        last_sent_wake = '0;
  logic signed [sod_pkg::TEMP_W-1:0] sent_temp = '0;
  logic [sod_pkg::HUM_W-1:0]         sent_hum = '0;
  logic [sod_pkg::BATT_W-1:0]        sent_batt = '0;

  sod_pkg::item_t   wakeup_queue[$];
  sod_pkg::result_t expected_reports[$];
  sod_pkg::item_t   in_item;
  sod_pkg::result_t got_report;
  sod_pkg::result_t exp_report;

  int wakeups_sent = 0;
  int reports_checked = 0;
  int mismatches = 0;
  int settings_used = 1;
  int status_seen[8];
  int cycles = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_left = 0;
  int rx_mode = 0;
  int rx_span = 0;
  int walk_t = 2000;
  int walk_h = 5000;
  int walk_b = 900;

  function automatic bit beyond_deadband(int x, int center, int half);
    return (x < center - half) || (x > center + half);
  endfunction

  function automatic sod_pkg::result_t predict_report(sod_pkg::item_t w);
    sod_pkg::result_t           r;
    logic                       hb;
    logic [sod_pkg::WAKE_W-1:0] elapsed;
    int                         t;
    int                         h;
    int                         b;
    r = '0;
    t = int'($signed(w.temperature_centi));
    h = int'(w.humidity_centi);
    b = int'(w.battery_raw);
    if (w.battery_raw <= cfg_shadow.low_battery_level) begin
      r.status = sod_pkg::ST_LOW_BATTERY;
    end else if (w.ota_request) begin
      hist_valid = 1'b0;
      r.status = sod_pkg::ST_OTA;
    end else if (!w.sensor_ok) begin
      r.status = sod_pkg::ST_SENSOR_FAIL;
    end else begin
      hb = 1'b0;
      if (hist_valid) begin
        wakes = wakes + 1'b1;
      end else begin
        wakes = 1;
        last_sent_wake = 1;
        hb = 1'b1;
      end
      elapsed = wakes - last_sent_wake;
      if (elapsed >= cfg_shadow.max_interval) hb = 1'b1;
      r.send_temperature = cfg_shadow.channel_enable[0] &&
        (hb || beyond_deadband(t, int'(sent_temp), int'(cfg_shadow.temp_delta)));
      r.send_humidity = cfg_shadow.channel_enable[1] &&
        (hb || beyond_deadband(h, int'(sent_hum), int'(cfg_shadow.humidity_delta)));
      r.send_voltage = cfg_shadow.channel_enable[2] &&
        (hb || beyond_deadband(b, int'(sent_batt), int'(cfg_shadow.voltage_delta)));
      hist_valid = 1'b1;
      if (r.send_temperature || r.send_humidity || r.send_voltage) begin
        if (w.delivery_ok) begin
          if (r.send_temperature) sent_temp = w.temperature_centi;
          if (r.send_humidity) sent_hum = w.humidity_centi;
          if (r.send_voltage) sent_batt = w.battery_raw;
          last_sent_wake = wakes;
          r.status = sod_pkg::ST_SENT_OK;
        end else begin
          r.status = sod_pkg::ST_SEND_FAIL;
        end
      end else begin
        r.status = sod_pkg::ST_NO_UPDATE;
      end
    end
    r.wake_number = wakes;
    return r;
  endfunction

  function automatic sod_pkg::item_t make_wakeup(int t, int h, int b, bit sok, bit ota,
                                                 bit dok);
    sod_pkg::item_t w;
    w.temperature_centi = t[sod_pkg::TEMP_W-1:0];
    w.humidity_centi    = h[sod_pkg::HUM_W-1:0];
    w.battery_raw       = b[sod_pkg::BATT_W-1:0];
    w.sensor_ok         = sok;
    w.ota_request       = ota;
    w.delivery_ok       = dok;
    return w;
  endfunction

  task automatic write_reg(sod_pkg::reg_idx_t idx, logic [sod_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      sod_pkg::REG_TEMP_DELTA:
        cfg_shadow.temp_delta = value[sod_pkg::TEMP_W-1:0];
      sod_pkg::REG_HUMIDITY_DELTA:
        cfg_shadow.humidity_delta = value[sod_pkg::HUM_W-1:0];
      sod_pkg::REG_VOLTAGE_DELTA:
        cfg_shadow.voltage_delta = value[sod_pkg::BATT_W-1:0];
      sod_pkg::REG_MAX_INTERVAL:
        cfg_shadow.max_interval = value[sod_pkg::INT_W-1:0];
      sod_pkg::REG_LOW_BATTERY:
        cfg_shadow.low_battery_level = value[sod_pkg::BATT_W-1:0];
      sod_pkg::REG_CHANNEL_ENABLE:
        cfg_shadow.channel_enable = value[sod_pkg::CHEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [15:0] td, logic [15:0] hd, logic [15:0] vd,
                                logic [15:0] mi, logic [15:0] lb, logic [15:0] ce);
    write_reg(sod_pkg::REG_TEMP_DELTA, td);
    write_reg(sod_pkg::REG_HUMIDITY_DELTA, hd);
    write_reg(sod_pkg::REG_VOLTAGE_DELTA, vd);
    write_reg(sod_pkg::REG_MAX_INTERVAL, mi);
    write_reg(sod_pkg::REG_LOW_BATTERY, lb);
    write_reg(sod_pkg::REG_CHANNEL_ENABLE, ce);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (wakeup_queue.size() != 0 || in_tvalid || expected_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // random walk around the deadbands, with jumps and bad wake-ups mixed in
  task automatic queue_random(int n);
    int span;
    int stp;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        walk_t = int'($urandom_range(0, 32767)) - 16384;
        walk_h = $urandom_range(0, 16383);
        walk_b = $urandom_range(0, 1023);
      end else begin
        span = int'(cfg_shadow.temp_delta) + 3;
        stp = $urandom_range(0, 2 * span);
        walk_t += stp - span;
        span = int'(cfg_shadow.humidity_delta) + 3;
        stp = $urandom_range(0, 2 * span);
        walk_h += stp - span;
        span = int'(cfg_shadow.voltage_delta) + 3;
        stp = $urandom_range(0, 2 * span);
        walk_b += stp - span;
        if (walk_t > 16383) walk_t = 16383;
        if (walk_t < -16384) walk_t = -16384;
        if (walk_h > 16383) walk_h = 16383;
        if (walk_h < 0) walk_h = 0;
        if (walk_b > 1023) walk_b = 1023;
        if (walk_b < 0) walk_b = 0;
        if (walk_b <= int'(cfg_shadow.low_battery_level) &&
            cfg_shadow.low_battery_level < 10'd1023 && $urandom_range(0, 3) != 0)
          walk_b = $urandom_range(int'(cfg_shadow.low_battery_level) + 1, 1023);
      end
      wakeup_queue.push_back(make_wakeup(walk_t, walk_h, walk_b,
        $urandom_range(0, 19) != 0, $urandom_range(0, 24) == 0, $urandom_range(0, 4) != 0));
    end
  endtask

  // input driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_reports.push_back(predict_report(in_item));
        wakeups_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || wakeup_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          in_item = wakeup_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= sod_pkg::IN_TDATA_W'(in_item);
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_report = sod_pkg::result_t'(out_tdata[$bits(sod_pkg::result_t)-1:0]);
        status_seen[got_report.status]++;
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report, got status %0d wake %0d", $time,
                   got_report.status, got_report.wake_number);
          mismatches++;
        end else begin
          exp_report = expected_reports.pop_front();
          reports_checked++;
          if (got_report.status !== exp_report.status) begin
            $display("%0t: status expected %0d got %0d", $time,
                     exp_report.status, got_report.status);
            mismatches++;
          end
          if (got_report.send_temperature !== exp_report.send_temperature) begin
            $display("%0t: send_temperature expected %0b got %0b", $time,
                     exp_report.send_temperature, got_report.send_temperature);
            mismatches++;
          end
          if (got_report.send_humidity !== exp_report.send_humidity) begin
            $display("%0t: send_humidity expected %0b got %0b", $time,
                     exp_report.send_humidity, got_report.send_humidity);
            mismatches++;
          end
          if (got_report.send_voltage !== exp_report.send_voltage) begin
            $display("%0t: send_voltage expected %0b got %0b", $time,
                     exp_report.send_voltage, got_report.send_voltage);
            mismatches++;
          end
          if (got_report.wake_number !== exp_report.wake_number) begin
            $display("%0t: wake_number expected %0d got %0d", $time,
                     exp_report.wake_number, got_report.wake_number);
            mismatches++;
          end
        end
      end
      if (rx_span == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_span = $urandom_range(20, 120);
      end else begin
        rx_span--;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        case (rx_mode)
          1: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 2);
          2: if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(4, 12);
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d reports outstanding", cycles,
               expected_reports.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    cfg_shadow = '{temp_delta: sod_pkg::TEMP_DELTA_RST,
                   humidity_delta: sod_pkg::HUM_DELTA_RST,
                   voltage_delta: sod_pkg::VOLT_DELTA_RST,
                   max_interval: sod_pkg::MAX_INTERVAL_RST,
                   low_battery_level: sod_pkg::LOW_BATT_RST,
                   channel_enable: sod_pkg::CHANNEL_EN_RST};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // priority order, deadband edges, first start and field extremes
    wakeup_queue.push_back(make_wakeup(0, 0, 0, 1, 0, 1));
    wakeup_queue.push_back(make_wakeup(0, 0, 737, 0, 1, 1));
    wakeup_queue.push_back(make_wakeup(0, 0, 738, 0, 1, 1));
    wakeup_queue.push_back(make_wakeup(0, 0, 1023, 0, 0, 1));
    wakeup_queue.push_back(make_wakeup(0, 0, 800, 1, 0, 0));
    wakeup_queue.push_back(make_wakeup(0, 0, 800, 1, 0, 1));
    wakeup_queue.push_back(make_wakeup(50, 0, 824, 1, 0, 1));
    wakeup_queue.push_back(make_wakeup(-50, 0, 776, 1, 0, 1));
    wakeup_queue.push_back(make_wakeup(51, 0, 825, 1, 0, 0));
    wakeup_queue.push_back(make_wakeup(51, 0, 825, 1, 0, 1));
    wakeup_queue.push_back(make_wakeup(-16384, 16383, 1023, 1, 0, 1));
    wakeup_queue.push_back(make_wakeup(16383, 0, 1023, 1, 0, 1));
    wakeup_queue.push_back(make_wakeup(-4500, 10000, 738, 1, 0, 1));
    wakeup_queue.push_back(make_wakeup(13000, 10000, 738, 1, 0, 1));
    wakeup_queue.push_back(make_wakeup(13000, 10000, 900, 0, 1, 0));
    wakeup_queue.push_back(make_wakeup(13000, 10000, 900, 1, 0, 1));
    wakeup_queue.push_back(make_wakeup(13000, 10000, 900, 1, 0, 1));
    queue_random(80);
    wait_idle();

    apply_settings(0, 0, 0, 1, 0, 7);
    queue_random(60);
    wait_idle();
    apply_settings(50, 200, 24, 0, 0, 5);
    queue_random(30);
    wait_idle();
    apply_settings(16'h7fff, 16'h3fff, 16'h3ff, 16'hffff, 0, 7);
    queue_random(30);
    wait_idle();
    apply_settings(50, 200, 24, 72, 16'h3ff, 0);
    queue_random(10);
    wait_idle();
    apply_settings(17500, 10000, 1023, 2, 600, 6);
    queue_random(60);
    wait_idle();
    repeat (4) begin
      apply_settings(
        16'($urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 300)),
        16'($urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 400)),
        16'($urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 40)),
        16'($urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 10)),
        16'($urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 800)),
        16'($urandom_range(0, 65535)));
      queue_random(60);
      wait_idle();
    end
    repeat (8) @(posedge clk);

    if (expected_reports.size() != 0) begin
      $display("%0t: %0d expected reports never arrived", $time, expected_reports.size());
      mismatches++;
    end
    $display("Checked %0d reports for %0d wake-ups across %0d register settings",
             reports_checked, wakeups_sent, settings_used);
    $display("Status mix: low battery %0d, update mode %0d, sensor fail %0d,",
             status_seen[sod_pkg::ST_LOW_BATTERY], status_seen[sod_pkg::ST_OTA],
             status_seen[sod_pkg::ST_SENSOR_FAIL],
             " no update %0d, sent %0d, send failed %0d",
             status_seen[sod_pkg::ST_NO_UPDATE], status_seen[sod_pkg::ST_SENT_OK],
             status_seen[sod_pkg::ST_SEND_FAIL]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
